@@ design/sbi_pkg.sv @@
package sbi_pkg;

	// Coordinate format: signed fixed point, FRAC_BITS fractional bits.
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// Magnitudes of numerator and direction, and the divider remainder.
	localparam int MAG_W      = COORD_WIDTH + 1;
	localparam int REM_W      = COORD_WIDTH + 2;
	// Quotient bits that matter: t is kept only up to 2.0.
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int DIV_STAGES = FRAC_BITS + 1;
	// Clamped t, signed, able to hold one plus one lsb.
	localparam int TQ_W       = QUO_W + 1;
	// Product of t and direction, its shifted form and the point sum.
	localparam int PROD_W     = TQ_W + MAG_W;
	localparam int OFF_W      = PROD_W - FRAC_BITS;
	localparam int PT_W       = OFF_W + 1;

	localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_BITS;

	// Configuration register indexes.
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [MAG_W-1:0]       diff_t;
	typedef logic [MAG_W-1:0]              mag_t;
	typedef logic [REM_W-1:0]              rem_t;
	typedef logic [QUO_W-1:0]              quo_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
	} in_t;

	typedef struct packed {
		logic   hit;
		coord_t hit_x;
		coord_t hit_y;
		coord_t hit_z;
	} out_t;

endpackage

@@ design/segment_box_intersection_top.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data  (segment start and end)
// out       output     out_valid / out_stall out_data (hit flag and point)
// cfg       input      APB psel / penable   box bounds, six registers
//
// From input transfer to result the path runs through two setup stages, one
// stage per quotient bit of the 17-stage divider, then select, multiply and
// check stages. One segment enters every cycle while the output is not stalled.
// The whole pipeline advances together; it holds only while a result waits at a
// stalled output. Reset clears the valid bits and the box registers.
module segment_box_intersection_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  sbi_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output sbi_pkg::out_t out_data,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef struct packed {
		sbi_pkg::coord_t [2:0] s;
		sbi_pkg::coord_t [2:0] plane;
		sbi_pkg::diff_t  [2:0] d;
		sbi_pkg::diff_t  [2:0] num;
		logic            [2:0] mid;
		logic            [2:0] neg;
		logic            [2:0] big;
		logic                  in_box;
	} side_t;

	// Configuration registers.
	sbi_pkg::coord_t lo_q [3];
	sbi_pkg::coord_t hi_q [3];
	logic [2:0] reg_idx;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sbi_pkg::REG_MIN_X: lo_q[0] <= pwdata;
				sbi_pkg::REG_MIN_Y: lo_q[1] <= pwdata;
				sbi_pkg::REG_MIN_Z: lo_q[2] <= pwdata;
				sbi_pkg::REG_MAX_X: hi_q[0] <= pwdata;
				sbi_pkg::REG_MAX_Y: hi_q[1] <= pwdata;
				sbi_pkg::REG_MAX_Z: hi_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_idx)
			sbi_pkg::REG_MIN_X: prdata = lo_q[0];
			sbi_pkg::REG_MIN_Y: prdata = lo_q[1];
			sbi_pkg::REG_MIN_Z: prdata = lo_q[2];
			sbi_pkg::REG_MAX_X: prdata = hi_q[0];
			sbi_pkg::REG_MAX_Y: prdata = hi_q[1];
			sbi_pkg::REG_MAX_Z: prdata = hi_q[2];
			default:            prdata = '0;
		endcase
	end

	// Global advance: the pipeline moves unless the output holds a stalled result.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: slab classification, direction and plane distance.
	sbi_pkg::coord_t st [3];
	sbi_pkg::coord_t ed [3];
	side_t side_c1, side_s1;
	logic  v_s1;
	assign st[0] = in_data.start_x;
	assign st[1] = in_data.start_y;
	assign st[2] = in_data.start_z;
	assign ed[0] = in_data.end_x;
	assign ed[1] = in_data.end_y;
	assign ed[2] = in_data.end_z;

	always_comb begin
		side_c1 = '0;
		for (int i = 0; i < 3; i++) begin
			side_c1.s[i] = st[i];
			side_c1.d[i] = sbi_pkg::MAG_W'(ed[i]) - sbi_pkg::MAG_W'(st[i]);
			if (st[i] < lo_q[i]) begin
				side_c1.plane[i] = lo_q[i];
			end else if (st[i] > hi_q[i]) begin
				side_c1.plane[i] = hi_q[i];
			end else begin
				side_c1.mid[i] = 1'b1;
			end
			side_c1.num[i] = sbi_pkg::MAG_W'(side_c1.plane[i]) - sbi_pkg::MAG_W'(st[i]);
		end
		side_c1.in_box = &side_c1.mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
		end
	end

	// Stage 2: magnitudes, and the cases the divider need not resolve.
	side_t         side_c2, side_s2;
	sbi_pkg::mag_t amag_c [3];
	sbi_pkg::mag_t dmag_c [3];
	sbi_pkg::mag_t amag_s2 [3];
	sbi_pkg::mag_t dmag_s2 [3];
	logic          v_s2;

	always_comb begin
		side_c2 = side_s1;
		for (int i = 0; i < 3; i++) begin
			amag_c[i] = side_s1.num[i][sbi_pkg::MAG_W-1] ? -side_s1.num[i] : side_s1.num[i];
			dmag_c[i] = side_s1.d[i][sbi_pkg::MAG_W-1] ? -side_s1.d[i] : side_s1.d[i];
			// Start inside the slab, no motion, or motion away: t is negative.
			side_c2.neg[i] = side_s1.mid[i] || (side_s1.d[i] == '0) ||
				(side_s1.num[i][sbi_pkg::MAG_W-1] != side_s1.d[i][sbi_pkg::MAG_W-1]);
			// Plane at least twice the segment length away: t above one.
			side_c2.big[i] = ({1'b0, amag_c[i]} >= {dmag_c[i], 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			for (int i = 0; i < 3; i++) begin
				amag_s2[i] <= amag_c[i];
				dmag_s2[i] <= dmag_c[i];
			end
		end
	end

	// Divider stages, with the side data and valid bits alongside.
	sbi_pkg::quo_t quo [3];
	for (genvar i = 0; i < 3; i++) begin : g_div
		sbi_div u_div (
			.clk (clk),
			.en  (en),
			.num (amag_s2[i]),
			.den (dmag_s2[i]),
			.quo (quo[i])
		);
	end

	side_t side_sd [sbi_pkg::DIV_STAGES];
	logic  v_sd    [sbi_pkg::DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sbi_pkg::DIV_STAGES; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else if (en) begin
			v_sd[0] <= v_s2;
			for (int k = 1; k < sbi_pkg::DIV_STAGES; k++) begin
				v_sd[k] <= v_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s2;
			for (int k = 1; k < sbi_pkg::DIV_STAGES; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	// Stage 3: clamp t per axis, pick the largest, lowest axis on ties.
	side_t side_dv;
	assign side_dv = side_sd[sbi_pkg::DIV_STAGES-1];

	logic signed [sbi_pkg::TQ_W-1:0] tq_c [3];
	logic [1:0]                      w_c;
	logic                            cand_c;
	side_t                           side_s3;
	logic [1:0]                      w_s3;
	sbi_pkg::quo_t                   tq_s3;
	logic                            cand_s3;
	logic                            v_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_dv.neg[i]) begin
				tq_c[i] = -sbi_pkg::TQ_W'(1);
			end else if (side_dv.big[i] || quo[i] > sbi_pkg::ONE_Q) begin
				tq_c[i] = sbi_pkg::TQ_W'(sbi_pkg::ONE_Q) + sbi_pkg::TQ_W'(1);
			end else begin
				tq_c[i] = sbi_pkg::TQ_W'(quo[i]);
			end
		end
		w_c = 2'd0;
		if (tq_c[1] > tq_c[0]) begin
			w_c = 2'd1;
		end
		if (tq_c[2] > tq_c[w_c]) begin
			w_c = 2'd2;
		end
		cand_c = !tq_c[w_c][sbi_pkg::TQ_W-1] &&
			(tq_c[w_c] <= sbi_pkg::TQ_W'(sbi_pkg::ONE_Q)) &&
			!((tq_c[w_c] == sbi_pkg::TQ_W'(sbi_pkg::ONE_Q)) &&
			(side_dv.num[w_c] != side_dv.d[w_c]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_sd[sbi_pkg::DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_dv;
			w_s3    <= w_c;
			tq_s3   <= tq_c[w_c][sbi_pkg::QUO_W-1:0];
			cand_s3 <= cand_c;
		end
	end

	// Stage 4: t times direction on every axis.
	logic signed [sbi_pkg::PROD_W-1:0] prod_s4 [3];
	side_t                             side_s4;
	logic [1:0]                        w_s4;
	logic                              cand_s4;
	logic                              v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= $signed({1'b0, tq_s3}) * side_s3.d[i];
			end
			side_s4 <= side_s3;
			w_s4    <= w_s3;
			cand_s4 <= cand_s3;
		end
	end

	// Stage 5: point on the segment, box check, output register.
	logic signed [sbi_pkg::OFF_W-1:0] off_c [3];
	logic signed [sbi_pkg::PT_W-1:0]  pt_c  [3];
	logic                             ok_c;
	sbi_pkg::coord_t                  res_c [3];
	sbi_pkg::out_t                    out_c;
	sbi_pkg::out_t                    out_s5;
	logic                             v_s5;

	always_comb begin
		ok_c = cand_s4;
		for (int i = 0; i < 3; i++) begin
			off_c[i] = prod_s4[i][sbi_pkg::PROD_W-1:sbi_pkg::FRAC_BITS];
			pt_c[i]  = sbi_pkg::PT_W'(side_s4.s[i]) + sbi_pkg::PT_W'(off_c[i]);
			if (w_s4 == 2'(i)) begin
				res_c[i] = side_s4.plane[i];
			end else begin
				res_c[i] = pt_c[i][sbi_pkg::COORD_WIDTH-1:0];
				if (pt_c[i] < sbi_pkg::PT_W'(lo_q[i]) || pt_c[i] > sbi_pkg::PT_W'(hi_q[i])) begin
					ok_c = 1'b0;
				end
			end
		end
		out_c = '0;
		if (side_s4.in_box) begin
			out_c.hit   = 1'b1;
			out_c.hit_x = side_s4.s[0];
			out_c.hit_y = side_s4.s[1];
			out_c.hit_z = side_s4.s[2];
		end else if (ok_c) begin
			out_c.hit   = 1'b1;
			out_c.hit_x = res_c[0];
			out_c.hit_y = res_c[1];
			out_c.hit_z = res_c[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5 <= out_c;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

`ifndef SYNTHESIS
	// A miss carries an all-zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_x == '0 &&
		out_data.hit_y == '0 && out_data.hit_z == '0)
		else $error("miss with nonzero point");

	// A candidate hit always has t within zero to one.
	a_cand_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cand_s3 |-> tq_s3 <= sbi_pkg::ONE_Q)
		else $error("candidate t out of range");

	// The input side is held back only while a result waits at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
`endif

endmodule

@@ design/sbi_div.sv @@
// Pipelined unsigned divider: quo = floor(num * 2^FRAC_BITS / den),
// one quotient bit per stage. The caller must keep num < 2 * den; the divider does not enforce it.
module sbi_div (
	input  logic          clk,
	input  logic          en,
	input  sbi_pkg::mag_t num,
	input  sbi_pkg::mag_t den,
	output sbi_pkg::quo_t quo
);

	sbi_pkg::rem_t rem_s [sbi_pkg::DIV_STAGES];
	sbi_pkg::mag_t den_s [sbi_pkg::DIV_STAGES];
	sbi_pkg::quo_t quo_s [sbi_pkg::DIV_STAGES];

	// First stage decides the integer bit of the quotient.
	logic ge0;
	assign ge0 = (num >= den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ge0 ? sbi_pkg::REM_W'(num - den) : sbi_pkg::REM_W'(num);
			den_s[0] <= den;
			quo_s[0] <= ge0 ? sbi_pkg::ONE_Q : '0;
		end
	end

	// Each later stage doubles the remainder and tries one subtraction.
	for (genvar k = 1; k < sbi_pkg::DIV_STAGES; k++) begin : g_step
		sbi_pkg::rem_t dbl;
		sbi_pkg::rem_t dext;
		sbi_pkg::quo_t qn;
		logic          ge;
		assign dbl  = {rem_s[k-1][sbi_pkg::REM_W-2:0], 1'b0};
		assign dext = sbi_pkg::REM_W'(den_s[k-1]);
		assign ge   = (dbl >= dext);

		// Quotient so far with this stage's bit filled in.
		always_comb begin
			qn = quo_s[k-1];
			qn[sbi_pkg::FRAC_BITS-k] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? dbl - dext : dbl;
				den_s[k] <= den_s[k-1];
				quo_s[k] <= qn;
			end
		end
	end

	assign quo = quo_s[sbi_pkg::DIV_STAGES-1];

endmodule

@@ dv/tb_segment_box_intersection_top.sv @@
`timescale 1ns / 1ps

module tb_segment_box_intersection_top;

	localparam int  LATENCY     = 22;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  LONG_HOLD   = 120;
	localparam longint ONE_T    = longint'(1) << sbi_pkg::FRAC_BITS;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	sbi_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	sbi_pkg::out_t out_data;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [4:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;

	// Box bounds as the block should hold them.
	sbi_pkg::coord_t box_lo[3];
	sbi_pkg::coord_t box_hi[3];

	sbi_pkg::in_t  segments_pending[$];
	sbi_pkg::out_t hits_expected[$];
	int   segments_queued = 0;
	int   segments_sent = 0;
	int   results_checked = 0;
	int   hits_seen = 0;
	int   errors = 0;
	int   cfg_writes = 0;
	int   cycles = 0;
	bit   quiet = 1'b0;
	bit   long_hold_done = 1'b0;

	segment_box_intersection_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Floor division, as the block rounds quotients toward minus infinity.
	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	// Slab test of one segment against the current box.
	function automatic sbi_pkg::out_t segment_hit(sbi_pkg::in_t seg);
		longint s[3], d[3], num[3], tq[3], plane[3], pt[3];
		bit     mid[3];
		bit     in_box;
		bit     hit;
		int     w;
		sbi_pkg::out_t r;
		in_box = 1'b1;
		hit = 1'b1;
		s[0] = seg.start_x; s[1] = seg.start_y; s[2] = seg.start_z;
		d[0] = longint'(seg.end_x) - s[0];
		d[1] = longint'(seg.end_y) - s[1];
		d[2] = longint'(seg.end_z) - s[2];
		for (int i = 0; i < 3; i++) begin
			mid[i] = 1'b0;
			plane[i] = 0;
			if (s[i] < box_lo[i]) begin
				plane[i] = box_lo[i];
				in_box = 1'b0;
			end else if (s[i] > box_hi[i]) begin
				plane[i] = box_hi[i];
				in_box = 1'b0;
			end else begin
				mid[i] = 1'b1;
			end
			num[i] = plane[i] - s[i];
		end
		r = '0;
		if (in_box) begin
			r.hit = 1'b1;
			r.hit_x = seg.start_x;
			r.hit_y = seg.start_y;
			r.hit_z = seg.start_z;
			return r;
		end
		for (int i = 0; i < 3; i++)
			tq[i] = (!mid[i] && d[i] != 0) ? floor_quot(num[i] * ONE_T, d[i]) : -ONE_T;
		w = 0;
		for (int i = 1; i < 3; i++)
			if (tq[w] < tq[i])
				w = i;
		// Beyond the end is judged exactly, before the start on the quantized t.
		if (tq[w] < 0 || tq[w] > ONE_T || (tq[w] == ONE_T && num[w] != d[w]))
			hit = 1'b0;
		for (int i = 0; i < 3 && hit; i++) begin
			if (i == w) begin
				pt[i] = plane[i];
			end else begin
				pt[i] = s[i] + floor_quot(tq[w] * d[i], ONE_T);
				if (pt[i] < box_lo[i] || pt[i] > box_hi[i])
					hit = 1'b0;
			end
		end
		if (hit) begin
			r.hit = 1'b1;
			r.hit_x = sbi_pkg::coord_t'(pt[0]);
			r.hit_y = sbi_pkg::coord_t'(pt[1]);
			r.hit_z = sbi_pkg::coord_t'(pt[2]);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0h expected %0h", results_checked, what, got,
			want);
		errors++;
	endtask

	// Input driver: offers queued segments, with random idle bursts.
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			hits_expected.push_back(segment_hit(in_data));
			segments_sent++;
		end
		if (!(in_valid && in_stall)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (segments_pending.size() > 0) begin
				in_data <= segments_pending.pop_front();
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					in_gap = $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall: random bursts, plus one long hold to back the pipeline up.
	int stall_left = 0;
	always @(posedge clk) begin
		if (!long_hold_done && segments_sent >= 300) begin
			long_hold_done = 1'b1;
			stall_left = LONG_HOLD;
		end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 5);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result monitor: each transfer against the oldest expectation.
	always @(posedge clk) begin
		sbi_pkg::out_t want;
		if (out_valid && !out_stall) begin
			if (hits_expected.size() == 0) begin
				report_mismatch("unexpected result hit_x", out_data.hit_x, 0);
			end else begin
				want = hits_expected.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch("hit", out_data.hit, want.hit);
				if (out_data.hit_x !== want.hit_x)
					report_mismatch("hit_x", out_data.hit_x, want.hit_x);
				if (out_data.hit_y !== want.hit_y)
					report_mismatch("hit_y", out_data.hit_y, want.hit_y);
				if (out_data.hit_z !== want.hit_z)
					report_mismatch("hit_z", out_data.hit_z, want.hit_z);
				if (want.hit)
					hits_seen++;
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle.
	task automatic cfg_write(logic [2:0] idx, sbi_pkg::coord_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= sbi_pkg::REG_MIN_Z)
			box_lo[idx] = val;
		else if (idx <= sbi_pkg::REG_MAX_Z)
			box_hi[idx - sbi_pkg::REG_MAX_X] = val;
		cfg_writes++;
	endtask

	task automatic set_box(sbi_pkg::coord_t lx, sbi_pkg::coord_t ly, sbi_pkg::coord_t lz,
			sbi_pkg::coord_t hx, sbi_pkg::coord_t hy, sbi_pkg::coord_t hz);
		cfg_write(sbi_pkg::REG_MIN_X, lx);
		cfg_write(sbi_pkg::REG_MIN_Y, ly);
		cfg_write(sbi_pkg::REG_MIN_Z, lz);
		cfg_write(sbi_pkg::REG_MAX_X, hx);
		cfg_write(sbi_pkg::REG_MAX_Y, hy);
		cfg_write(sbi_pkg::REG_MAX_Z, hz);
	endtask

	task automatic wait_drained();
		while (results_checked != segments_queued)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic add_segment(sbi_pkg::coord_t sx, sbi_pkg::coord_t sy, sbi_pkg::coord_t sz,
			sbi_pkg::coord_t ex, sbi_pkg::coord_t ey, sbi_pkg::coord_t ez);
		segments_pending.push_back({sx, sy, sz, ex, ey, ez});
		segments_queued++;
	endtask

	function automatic sbi_pkg::coord_t fx(int v);
		return sbi_pkg::coord_t'(v) <<< sbi_pkg::FRAC_BITS;
	endfunction

	// Coordinate near one box axis, sometimes on a plane or at the range ends.
	function automatic sbi_pkg::coord_t pick_coord(sbi_pkg::coord_t lo, sbi_pkg::coord_t hi);
		longint a, b, span, v;
		a = lo;
		b = hi;
		if (a > b) begin
			v = a; a = b; b = v;
		end
		span = b - a + 1;
		case ($urandom_range(0, 11))
			0: return sbi_pkg::coord_t'($urandom);
			1: return lo;
			2: return hi;
			3: return sbi_pkg::coord_t'(32'h8000_0000);
			4: return sbi_pkg::coord_t'(32'h7fff_ffff);
			default: begin
				v = a - span / 2 + longint'({$urandom, $urandom} % (2 * span));
				if (v < -(longint'(1) << 31)) v = -(longint'(1) << 31);
				if (v > (longint'(1) << 31) - 1) v = (longint'(1) << 31) - 1;
				return sbi_pkg::coord_t'(v);
			end
		endcase
	endfunction

	task automatic add_random(int n);
		sbi_pkg::coord_t s[3], e[3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					s[i] = sbi_pkg::coord_t'($urandom);
					e[i] = sbi_pkg::coord_t'($urandom);
				end else begin
					s[i] = pick_coord(box_lo[i], box_hi[i]);
					e[i] = ($urandom_range(0, 5) == 0) ? s[i] : pick_coord(box_lo[i], box_hi[i]);
				end
			end
			add_segment(s[0], s[1], s[2], e[0], e[1], e[2]);
		end
	endtask

	task automatic random_box();
		sbi_pkg::coord_t a, b;
		for (int i = 0; i < 3; i++) begin
			a = sbi_pkg::coord_t'($urandom_range(0, 32'h000f_ffff)) - fx(8);
			b = a + sbi_pkg::coord_t'($urandom_range(0, 32'h0010_0000));
			cfg_write(3'(sbi_pkg::REG_MIN_X + i), a);
			cfg_write(3'(sbi_pkg::REG_MAX_X + i), b);
		end
	endtask

	initial begin
		sbi_pkg::coord_t p;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = '0;
			box_hi[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset box: a single point at the origin.
		add_random(40);
		wait_drained();

		// Directed cases against a cube of half size four.
		set_box(fx(-4), fx(-4), fx(-4), fx(4), fx(4), fx(4));
		// Writes to unused register slots must be ignored.
		cfg_write(3'd6, fx(100));
		cfg_write(3'd7, fx(-100));
		add_segment(fx(1), fx(2), fx(3), fx(1), fx(2), fx(3));
		add_segment(fx(4), fx(-4), fx(4), fx(9), fx(9), fx(9));
		add_segment(fx(-8), fx(0), fx(0), fx(8), fx(1), fx(0));
		add_segment(fx(-8), fx(0), fx(0), fx(-9), fx(0), fx(0));
		add_segment(fx(-6), fx(-6), fx(0), fx(6), fx(6), fx(0));
		add_segment(fx(-6), fx(6), fx(-6), fx(6), fx(-6), fx(6));
		add_segment(fx(-8), fx(0), fx(0), fx(-5), fx(0), fx(0));
		add_segment(fx(-8), fx(0), fx(0), fx(-4), fx(0), fx(0));
		add_segment(fx(-8), fx(9), fx(0), fx(8), fx(9), fx(0));
		add_segment(fx(0), fx(-8), fx(0), fx(0), fx(8), fx(20));
		add_segment(fx(0), fx(0), fx(-8), fx(1), fx(1), fx(8));
		add_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_segment(32'h8000_0000, fx(0), fx(0), 32'h7fff_ffff, fx(0), fx(0));
		// Quantized t of exactly one while the end stops one step short.
		p = fx(-4);
		add_segment(p - 100001, fx(1), fx(1), p - 1, fx(1), fx(1));
		add_segment(fx(-9), fx(-9), fx(-9), fx(-4), fx(-4), fx(-4));
		add_segment(fx(9), fx(1), fx(1), fx(3), fx(1), fx(1));
		add_segment(fx(9), fx(1), fx(1), fx(4), fx(1), fx(1));
		add_segment(fx(5), fx(5), fx(5), fx(-5), fx(-5), fx(-5));
		add_random(500);
		wait_drained();

		// Box spanning the full range: every start is inside.
		set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_random(120);
		wait_drained();

		// Inverted box: min above max on every axis.
		set_box(fx(3), fx(3), fx(3), fx(-3), fx(-3), fx(-3));
		add_random(120);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			random_box();
			add_random(200);
			wait_drained();
		end

		// Final stretch with both sides running flat out.
		random_box();
		quiet = 1'b1;
		add_random(200);
		wait_drained();

		$display("covered %0d segments over %0d register writes, %0d hits",
			segments_sent, cfg_writes, hits_seen);
		if (errors == 0 && hits_expected.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", errors, hits_expected.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
